// ===== src/mvi_pkg.sv =====
// shared constants, types and helpers for the value iteration sweep block
`default_nettype none

package mvi_pkg;

	// sizes of the process
	localparam int NUM_STATES  = 16;
	localparam int NUM_ACTIONS = 4;

	localparam int ST_W      = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int AC_W      = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
	localparam int TBL_DEPTH = NUM_STATES * NUM_ACTIONS * NUM_STATES;
	localparam int TBL_W     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

	// accumulator for up to 16 products of 49 bits
	localparam int ACC_W = 56;

	// discount of one in Q1.16
	localparam logic [16:0] DISC_ONE = 17'd65536;

	// register reset values
	localparam logic [16:0] DISCOUNT_RST = 17'd58982;
	localparam logic [6:0]  STATES_RST   = 7'd16;
	localparam logic [4:0]  ACTIONS_RST  = 5'd4;

	// register indexes
	localparam logic [1:0] REG_DISCOUNT = 2'd0;
	localparam logic [1:0] REG_STATES   = 2'd1;
	localparam logic [1:0] REG_ACTIONS  = 2'd2;

	// item kinds
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_SWEEP = 1'b1;

	// control tag that travels down the multiply-accumulate pipeline
	typedef struct packed {
		logic            vld;
		logic            dvop;    // discounted value product, not a table term
		logic            empty;   // no actions in use, value is zero
		logic [ST_W-1:0] s;
		logic [AC_W-1:0] a;
		logic [ST_W-1:0] t;
		logic            first_t;
		logic            last_t;
		logic            first_a;
		logic            last_a;
		logic            last_s;
	} tag_t;

	// flat table address of (state, action, next state)
	function automatic logic [TBL_W-1:0] tbl_addr(input logic [ST_W-1:0] s,
			input logic [AC_W-1:0] a, input logic [ST_W-1:0] t);
		return TBL_W'((int'(s) * NUM_ACTIONS + int'(a)) * NUM_STATES + int'(t));
	endfunction

endpackage

`default_nettype wire

// ===== src/mdp_value_iteration_sweep.sv =====
// top level: bellman value iteration sweep over fixed-point transition tables
`default_nettype none

// Value iteration for a Markov decision process. A load item (action 0) writes
// one probability and reward into the transition table; an out-of-range
// address is dropped. A sweep item (action 1) bumps the sweep count, then runs
// over every state in use and reports one result item per state, in state
// order, with last set on the final one. With ns states in use, a sweep
// first makes one pass of ns multiplies that forms discount * old value for
// each next state, then walks the table with one multiply-accumulate per
// cycle while the result output is not stalled. That rate is set by the
// single shared 18x33 multiplier and the single read port of the table
// memory. Item input is stalled for the whole sweep; the final result has
// left the output register before the next item is taken. A stalled result
// output holds the whole pipeline. After reset the table memory is cleared
// entry by entry before the first item is taken; register writes are
// taken during that pass.
module mdp_value_iteration_sweep (
	input  logic               clk,
	input  logic               arst_n,
	// item channel
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               action,
	input  logic [5:0]         from_state,
	input  logic [3:0]         mdp_action,
	input  logic [5:0]         to_state,
	input  logic [15:0]        probability,
	input  logic signed [15:0] reward,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic [5:0]         state_index,
	output logic signed [31:0] state_value,
	output logic [3:0]         best_action,
	output logic [31:0]        sweep_number,
	output logic               last,
	// register write port
	input  logic               write_enable,
	input  logic [1:0]         register_index,
	input  logic [16:0]        write_data
);

	// sequencer phases
	localparam logic [2:0] PH_CLEAR = 3'd0;
	localparam logic [2:0] PH_IDLE  = 3'd1;
	localparam logic [2:0] PH_DV    = 3'd2;
	localparam logic [2:0] PH_DRAIN = 3'd3;
	localparam logic [2:0] PH_MAC   = 3'd4;
	localparam logic [2:0] PH_TAIL  = 3'd5;

	// configuration registers
	logic [16:0] discount_q;
	logic [6:0]  states_q;
	logic [4:0]  actions_q;

	// sequencer
	logic [2:0]                   state_q;
	logic [mvi_pkg::TBL_W-1:0]    clr_idx_q;
	logic                         drain_q;
	logic [mvi_pkg::ST_W-1:0]     s_q;
	logic [mvi_pkg::AC_W-1:0]     a_q;
	logic [mvi_pkg::ST_W-1:0]     t_q;
	logic [31:0]                  sweep_cnt_q;

	// value stores
	logic signed [31:0]        vals_q [mvi_pkg::NUM_STATES];
	logic [mvi_pkg::AC_W-1:0]  pol_q  [mvi_pkg::NUM_STATES];
	logic signed [31:0]        dv_q   [mvi_pkg::NUM_STATES];

	// transition table: probability in the upper half, reward in the lower
	logic [31:0] mem_q [mvi_pkg::TBL_DEPTH];

	// pipeline
	mvi_pkg::tag_t tag_s1, tag_s2, tag_s3, tag_s4;
	logic [31:0]                   rd_s1;
	logic signed [31:0]            dv_s1;
	logic signed [17:0]            mul_a_s2;
	logic signed [32:0]            mul_b_s2;
	logic signed [50:0]            prod_s3;
	logic signed [mvi_pkg::ACC_W-1:0] acc_q;
	logic signed [31:0]            best_q;
	logic [mvi_pkg::AC_W-1:0]      besta_q;

	// output register
	logic                     result_valid_q;
	logic [mvi_pkg::ST_W-1:0] res_s_q;
	logic signed [31:0]       res_val_q;
	logic [mvi_pkg::AC_W-1:0] res_act_q;
	logic [31:0]              res_sweep_q;
	logic                     res_last_q;

	// combinational
	logic                     adv;
	logic                     item_acc;
	logic                     load_ok;
	logic [16:0]              disc_c;
	logic [6:0]               ns_c, ns_m1;
	logic [4:0]               na_c, na_m1;
	logic                     na_zero;
	logic                     t_last, a_last, s_last, mac_end;
	logic                     mac_issue, dv_issue;
	mvi_pkg::tag_t            issue_tag, dv_tag;
	logic [mvi_pkg::TBL_W-1:0] issue_addr;
	logic                     mem_we;
	logic [mvi_pkg::TBL_W-1:0] mem_wa;
	logic [31:0]              mem_wd;
	logic signed [32:0]       term_c;
	logic signed [40:0]       shr_c;
	logic signed [31:0]       q_c;
	logic                     q_sel;
	logic signed [31:0]       cand_val;
	logic [mvi_pkg::AC_W-1:0] cand_act;
	logic                     q_take, res_emit;
	logic                     pipe_empty;

	// the whole sweep pipeline freezes while a result waits on a stalled output
	assign adv      = !(result_valid_q && result_stall);
	assign item_stall = (state_q != PH_IDLE);
	assign item_acc = item_valid && !item_stall;

	assign load_ok = ({1'b0, from_state} < 7'(mvi_pkg::NUM_STATES)) &&
		({1'b0, mdp_action} < 5'(mvi_pkg::NUM_ACTIONS)) &&
		({1'b0, to_state} < 7'(mvi_pkg::NUM_STATES));

	// clamped register values
	assign disc_c  = (discount_q > mvi_pkg::DISC_ONE) ? mvi_pkg::DISC_ONE : discount_q;
	assign ns_c    = (states_q > 7'(mvi_pkg::NUM_STATES)) ? 7'(mvi_pkg::NUM_STATES) : states_q;
	assign na_c    = (actions_q > 5'(mvi_pkg::NUM_ACTIONS)) ?
		5'(mvi_pkg::NUM_ACTIONS) : actions_q;
	assign ns_m1   = ns_c - 7'd1;
	assign na_m1   = na_c - 5'd1;
	assign na_zero = (na_c == 5'd0);

	// loop bounds of the walk over (state, action, next state)
	assign t_last  = (7'(t_q) == ns_m1);
	assign a_last  = na_zero || (5'(a_q) == na_m1);
	assign s_last  = (7'(s_q) == ns_m1);
	assign mac_end = s_last && (na_zero || (t_last && a_last));

	assign mac_issue = (state_q == PH_MAC) && adv;
	assign dv_issue  = (state_q == PH_DV) && adv;

	always_comb begin
		issue_tag         = '0;
		issue_tag.vld     = 1'b1;
		issue_tag.empty   = na_zero;
		issue_tag.s       = s_q;
		issue_tag.a       = a_q;
		issue_tag.t       = t_q;
		issue_tag.first_t = (t_q == '0);
		issue_tag.last_t  = na_zero || t_last;
		issue_tag.first_a = (a_q == '0);
		issue_tag.last_a  = a_last;
		issue_tag.last_s  = s_last;
	end

	always_comb begin
		dv_tag      = '0;
		dv_tag.vld  = 1'b1;
		dv_tag.dvop = 1'b1;
		dv_tag.t    = t_q;
	end

	assign issue_addr = mvi_pkg::tbl_addr(s_q, a_q, t_q);

	// table write port: clearing pass or load item
	always_comb begin
		if (state_q == PH_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_idx_q;
			mem_wd = '0;
		end else begin
			mem_we = item_acc && (action == mvi_pkg::ACT_LOAD) && load_ok;
			mem_wa = mvi_pkg::tbl_addr(from_state[mvi_pkg::ST_W-1:0],
				mdp_action[mvi_pkg::AC_W-1:0], to_state[mvi_pkg::ST_W-1:0]);
			mem_wd = {probability, reward};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (mac_issue) begin
			rd_s1 <= mem_q[issue_addr];
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discount_q <= mvi_pkg::DISCOUNT_RST;
			states_q   <= mvi_pkg::STATES_RST;
			actions_q  <= mvi_pkg::ACTIONS_RST;
		end else if (write_enable) begin
			case (register_index)
				mvi_pkg::REG_DISCOUNT: discount_q <= write_data;
				mvi_pkg::REG_STATES:   states_q   <= write_data[6:0];
				mvi_pkg::REG_ACTIONS:  actions_q  <= write_data[4:0];
				default: ;
			endcase
		end
	end

	assign pipe_empty = !tag_s1.vld && !tag_s2.vld && !tag_s3.vld && !tag_s4.vld;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= PH_CLEAR;
			clr_idx_q   <= '0;
			drain_q     <= 1'b0;
			s_q         <= '0;
			a_q         <= '0;
			t_q         <= '0;
			sweep_cnt_q <= '0;
		end else begin
			case (state_q)
				PH_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == mvi_pkg::TBL_W'(mvi_pkg::TBL_DEPTH - 1)) begin
						state_q <= PH_IDLE;
					end
				end
				PH_IDLE: begin
					if (item_acc && (action == mvi_pkg::ACT_SWEEP)) begin
						sweep_cnt_q <= sweep_cnt_q + 32'd1;
						t_q         <= '0;
						if (ns_c != 7'd0) begin
							state_q <= PH_DV;
						end
					end
				end
				PH_DV: begin
					if (adv) begin
						if (t_last) begin
							t_q     <= '0;
							drain_q <= 1'b0;
							state_q <= PH_DRAIN;
						end else begin
							t_q <= t_q + 1'b1;
						end
					end
				end
				PH_DRAIN: begin
					// lets the last discounted value land before the walk reads it
					if (adv) begin
						drain_q <= 1'b1;
						if (drain_q) begin
							s_q     <= '0;
							a_q     <= '0;
							t_q     <= '0;
							state_q <= PH_MAC;
						end
					end
				end
				PH_MAC: begin
					if (adv) begin
						if (na_zero) begin
							s_q <= s_q + 1'b1;
						end else if (t_last) begin
							t_q <= '0;
							if (a_last) begin
								a_q <= '0;
								s_q <= s_q + 1'b1;
							end else begin
								a_q <= a_q + 1'b1;
							end
						end else begin
							t_q <= t_q + 1'b1;
						end
						if (mac_end) begin
							state_q <= PH_TAIL;
						end
					end
				end
				PH_TAIL: begin
					if (adv && pipe_empty) begin
						state_q <= PH_IDLE;
					end
				end
				default: state_q <= PH_IDLE;
			endcase
		end
	end

	// pipeline tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else if (adv) begin
			tag_s1 <= mac_issue ? issue_tag : '0;
			tag_s2 <= dv_issue ? dv_tag : tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	// reward in Q16.16 plus discounted old value
	assign term_c = 33'(signed'({rd_s1[15:0], 8'd0})) + 33'(dv_s1);

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			if (mac_issue) begin
				dv_s1 <= dv_q[t_q];
			end
			// stage 2: operands of the shared multiplier
			if (dv_issue) begin
				mul_a_s2 <= signed'({1'b0, disc_c});
				mul_b_s2 <= 33'(vals_q[t_q]);
			end else begin
				mul_a_s2 <= signed'({2'b00, rd_s1[31:16]});
				mul_b_s2 <= term_c;
			end
			// stage 3: the multiply
			prod_s3 <= mul_a_s2 * mul_b_s2;
			// stage 4: store discounted value or accumulate a term
			if (tag_s3.vld && tag_s3.dvop) begin
				dv_q[tag_s3.t] <= prod_s3[47:16];
			end
			if (tag_s3.vld && !tag_s3.dvop && !tag_s3.empty) begin
				acc_q <= (tag_s3.first_t ? '0 : acc_q) + mvi_pkg::ACC_W'(prod_s3);
			end
			// stage 5: running best over actions
			if (q_take) begin
				best_q  <= cand_val;
				besta_q <= cand_act;
			end
		end
	end

	// floor to Q16.16 and saturate
	assign shr_c = acc_q[mvi_pkg::ACC_W-1:15];
	always_comb begin
		if (shr_c[40:31] == {10{shr_c[31]}}) begin
			q_c = shr_c[31:0];
		end else if (shr_c[40]) begin
			q_c = 32'sh8000_0000;
		end else begin
			q_c = 32'sh7fff_ffff;
		end
	end

	// lowest action wins ties
	assign q_sel    = tag_s4.first_a || (q_c > best_q);
	assign cand_val = q_sel ? q_c : best_q;
	assign cand_act = q_sel ? tag_s4.a : besta_q;

	assign q_take   = adv && tag_s4.vld && !tag_s4.dvop && !tag_s4.empty && tag_s4.last_t;
	assign res_emit = adv && tag_s4.vld && !tag_s4.dvop && tag_s4.last_t && tag_s4.last_a;

	// new values and policy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mvi_pkg::NUM_STATES; i++) begin
				vals_q[i] <= '0;
				pol_q[i]  <= '0;
			end
		end else if (res_emit) begin
			vals_q[tag_s4.s] <= tag_s4.empty ? 32'sd0 : cand_val;
			if (!tag_s4.empty) begin
				pol_q[tag_s4.s] <= cand_act;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_emit) begin
			res_s_q     <= tag_s4.s;
			res_val_q   <= tag_s4.empty ? 32'sd0 : cand_val;
			res_act_q   <= tag_s4.empty ? pol_q[tag_s4.s] : cand_act;
			res_sweep_q <= sweep_cnt_q;
			res_last_q  <= tag_s4.last_s;
		end
	end

	assign result_valid = result_valid_q;
	assign state_index  = 6'(res_s_q);
	assign state_value  = res_val_q;
	assign best_action  = 4'(res_act_q);
	assign sweep_number = res_sweep_q;
	assign last         = res_last_q;

endmodule

`default_nettype wire
